[hw/rtl/nths_pkg.sv]
// Shared types and constants for the nearest-target homing step block.
`default_nettype none

package nths_pkg;

   // Item field widths.
   localparam int POS_W      = 16;
   localparam int SLOT_W     = 3;
   localparam int VEL_W      = 9;
   localparam int SPEED_W    = 8;
   localparam int SLOT_COUNT = 8;

   // Datapath widths: difference, square, root, scaled numerator, quotient.
   localparam int D_W    = POS_W + 1;
   localparam int MUL_W  = D_W + 1;
   localparam int SQ_W   = 2 * D_W;
   localparam int ROOT_W = D_W;
   localparam int NUM_W  = D_W - 1 + SPEED_W;
   localparam int Q_W    = SPEED_W;

   // Stream and register port widths.
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 56;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // Register reset value and register index.
   localparam logic [SPEED_W-1:0] SPEED_RESET = 8'd10;
   localparam logic               REG_SPEED   = 1'b0;

   // Input word kinds.
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_CMP,
      ST_ROOT_GO,
      ST_ROOT,
      ST_MUL_X,
      ST_DIV_X,
      ST_MUL_Y,
      ST_DIV_Y,
      ST_DONE
   } nths_state_type;

endpackage

`default_nettype wire

[hw/rtl/nearest_target_homing_step.sv]
// Top level: target table, scan sequencer, shared multiplier and result register.
// A target write is accepted in the idle state. A query scans every slot in turn on
// one shared multiplier: square the x offset, square the y offset, compare. When the
// mover steps, the square root and the two divisions follow; then the result is
// loaded, and a full result register holds the query in its last state. The next word
// is accepted in the cycle after the result is loaded, so none is taken mid-query.
// Reset clears the valid marks and sets speed to 10; positions are not cleared.
`default_nettype none

module nearest_target_homing_step
   import nths_pkg::*;
#(
   parameter int MAX_TARGETS = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Request words.
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // slot[2:0], slot_valid[3], pos_x[19:4], pos_y[35:20], zero fill above
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // kind[0]
   input  wire logic                   req_tuser,
   // Response words.
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // vel_x[8:0], vel_y[17:9], new_x[33:18], new_y[49:34], zero fill above
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   // moved[0]
   output logic                        rsp_tuser,
   // Register port.
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]       csr_prdata,
   output logic                        csr_pready
);

   localparam int DEPTH = (MAX_TARGETS < SLOT_COUNT) ? MAX_TARGETS : SLOT_COUNT;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam int RSP_PAD_W = RSP_TDATA_W - 2 * VEL_W - 2 * POS_W;

   nths_state_type state_ff, state_in;

   logic [SPEED_W-1:0]      speed_ff, speed_in;
   logic [POS_W-1:0]        px_ff, px_in;
   logic [POS_W-1:0]        py_ff, py_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic signed [D_W-1:0]   dx_ff, dx_in;
   logic signed [D_W-1:0]   dy_ff, dy_in;
   logic [SQ_W-1:0]         sqx_ff, sqx_in;
   logic [SQ_W-1:0]         sqy_ff, sqy_in;
   logic                    found_ff, found_in;
   logic [SQ_W-1:0]         best_ff, best_in;
   logic signed [D_W-1:0]   bdx_ff, bdx_in;
   logic signed [D_W-1:0]   bdy_ff, bdy_in;
   logic [ROOT_W-1:0]       mag_ff, mag_in;
   logic [VEL_W-1:0]        velx_ff, velx_in;
   logic [VEL_W-1:0]        vely_ff, vely_in;
   logic                    moved_ff, moved_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic                    rsp_tuser_ff, rsp_tuser_in;
   logic [RSP_TDATA_W-1:0]  rsp_tdata_ff, rsp_tdata_in;

   logic                    req_fire;
   logic                    csr_write;
   logic                    tbl_wr;
   logic                    tbl_valid;
   logic [POS_W-1:0]        tbl_x;
   logic [POS_W-1:0]        tbl_y;
   logic signed [D_W-1:0]   dx_cur;
   logic signed [D_W-1:0]   dy_cur;
   logic [SQ_W-1:0]         d2;
   logic [D_W-1:0]          abs_x;
   logic [D_W-1:0]          abs_y;
   logic signed [MUL_W-1:0] mul_a;
   logic signed [MUL_W-1:0] mul_b;
   logic signed [2*MUL_W-1:0] mul_p;
   logic                    sqrt_start;
   logic                    sqrt_done;
   logic [ROOT_W-1:0]       sqrt_root;
   logic                    div_start;
   logic                    div_done;
   logic [Q_W-1:0]          div_q;
   logic                    out_free;

   // Signed velocity from a quotient magnitude and the sign of the offset.
   function automatic logic [VEL_W-1:0] to_vel(input logic neg, input logic [Q_W-1:0] q);
      logic [VEL_W-1:0] mag;
      mag = {1'b0, q};
      return neg ? VEL_W'(-mag) : mag;
   endfunction

   // Position plus velocity, clamped to the signed position range.
   function automatic logic [POS_W-1:0] sat_pos(input logic [POS_W-1:0] p,
                                                input logic [VEL_W-1:0] v);
      logic [POS_W:0] sum;
      sum = {p[POS_W-1], p} + {{(POS_W + 1 - VEL_W){v[VEL_W-1]}}, v};
      if (sum[POS_W] != sum[POS_W-1]) begin
         return sum[POS_W] ? {1'b1, {(POS_W - 1){1'b0}}} : {1'b0, {(POS_W - 1){1'b1}}};
      end
      return sum[POS_W-1:0];
   endfunction

   // Register port: one writable register, always ready.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign speed_in   = (csr_write && (csr_paddr[2] == REG_SPEED)) ?
                       csr_pwdata[SPEED_W-1:0] : speed_ff;
   assign csr_prdata = (csr_paddr[2] == REG_SPEED) ?
                       {{(CSR_DATA_W - SPEED_W){1'b0}}, speed_ff} : '0;

   // Target table, written directly from an accepted write word.
   assign req_fire = req_tvalid && req_tready;
   assign tbl_wr   = req_fire && (req_tuser == KIND_WRITE);

   nths_target_table #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (tbl_wr),
      .wr_slot  (req_tdata[SLOT_W-1:0]),
      .wr_valid (req_tdata[SLOT_W]),
      .wr_x     (req_tdata[SLOT_W+1 +: POS_W]),
      .wr_y     (req_tdata[SLOT_W+1+POS_W +: POS_W]),
      .rd_idx   (idx_ff),
      .rd_valid (tbl_valid),
      .rd_x     (tbl_x),
      .rd_y     (tbl_y)
   );

   // Offsets from the mover to the slot under scan, and the shared multiplier.
   assign dx_cur = $signed({tbl_x[POS_W-1], tbl_x}) - $signed({px_ff[POS_W-1], px_ff});
   assign dy_cur = $signed({tbl_y[POS_W-1], tbl_y}) - $signed({py_ff[POS_W-1], py_ff});
   assign d2     = sqx_ff + sqy_ff;
   assign abs_x  = bdx_ff[D_W-1] ? D_W'(-bdx_ff) : D_W'(bdx_ff);
   assign abs_y  = bdy_ff[D_W-1] ? D_W'(-bdy_ff) : D_W'(bdy_ff);
   assign mul_p  = mul_a * mul_b;

   nths_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (best_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   nths_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (mul_p[NUM_W-1:0]),
      .den   (mag_ff),
      .done  (div_done),
      .quot  (div_q)
   );

   assign out_free = !rsp_tvalid_ff || rsp_tready;

   // Sequencer: next state, datapath register updates and unit controls.
   always_comb begin
      state_in      = state_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      idx_in        = idx_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      sqx_in        = sqx_ff;
      sqy_in        = sqy_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      bdx_in        = bdx_ff;
      bdy_in        = bdy_ff;
      mag_in        = mag_ff;
      velx_in       = velx_ff;
      vely_in       = vely_ff;
      moved_in      = moved_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      req_tready    = 1'b0;
      mul_a         = '0;
      mul_b         = '0;
      sqrt_start    = 1'b0;
      div_start     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && (req_tuser == KIND_QUERY)) begin
               px_in    = req_tdata[SLOT_W+1 +: POS_W];
               py_in    = req_tdata[SLOT_W+1+POS_W +: POS_W];
               idx_in   = '0;
               found_in = 1'b0;
               best_in  = '0;
               velx_in  = '0;
               vely_in  = '0;
               moved_in = 1'b0;
               state_in = ST_SQ_X;
            end
         end
         ST_SQ_X: begin
            mul_a    = {dx_cur[D_W-1], dx_cur};
            mul_b    = {dx_cur[D_W-1], dx_cur};
            sqx_in   = mul_p[SQ_W-1:0];
            dx_in    = dx_cur;
            state_in = ST_SQ_Y;
         end
         ST_SQ_Y: begin
            mul_a    = {dy_cur[D_W-1], dy_cur};
            mul_b    = {dy_cur[D_W-1], dy_cur};
            sqy_in   = mul_p[SQ_W-1:0];
            dy_in    = dy_cur;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            // Strict less-than keeps the lowest index on a tie.
            if (tbl_valid && (!found_ff || (d2 < best_ff))) begin
               found_in = 1'b1;
               best_in  = d2;
               bdx_in   = dx_ff;
               bdy_in   = dy_ff;
            end
            if (idx_ff == LAST_IDX) begin
               if (found_in && (best_in != '0)) begin
                  moved_in = 1'b1;
                  state_in = ST_ROOT_GO;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SQ_X;
            end
         end
         ST_ROOT_GO: begin
            sqrt_start = 1'b1;
            state_in   = ST_ROOT;
         end
         ST_ROOT: begin
            if (sqrt_done) begin
               mag_in   = sqrt_root;
               state_in = ST_MUL_X;
            end
         end
         ST_MUL_X: begin
            mul_a     = {1'b0, abs_x};
            mul_b     = {{(MUL_W - SPEED_W){1'b0}}, speed_ff};
            div_start = 1'b1;
            state_in  = ST_DIV_X;
         end
         ST_DIV_X: begin
            if (div_done) begin
               velx_in  = to_vel(bdx_ff[D_W-1], div_q);
               state_in = ST_MUL_Y;
            end
         end
         ST_MUL_Y: begin
            mul_a     = {1'b0, abs_y};
            mul_b     = {{(MUL_W - SPEED_W){1'b0}}, speed_ff};
            div_start = 1'b1;
            state_in  = ST_DIV_Y;
         end
         ST_DIV_Y: begin
            if (div_done) begin
               vely_in  = to_vel(bdy_ff[D_W-1], div_q);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Load the result word once the output register is free.
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tuser_in  = moved_ff;
               rsp_tdata_in  = {{RSP_PAD_W{1'b0}},
                                sat_pos(py_ff, vely_ff),
                                sat_pos(px_ff, velx_ff),
                                vely_ff, velx_ff};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         speed_ff      <= SPEED_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         speed_ff      <= speed_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      px_ff        <= px_in;
      py_ff        <= py_in;
      idx_ff       <= idx_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      sqx_ff       <= sqx_in;
      sqy_ff       <= sqy_in;
      found_ff     <= found_in;
      best_ff      <= best_in;
      bdx_ff       <= bdx_in;
      bdy_ff       <= bdy_in;
      mag_ff       <= mag_in;
      velx_ff      <= velx_in;
      vely_ff      <= vely_in;
      moved_ff     <= moved_in;
      rsp_tuser_ff <= rsp_tuser_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // A finished query always leaves a word in the output register.
   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> rsp_tvalid_ff)
      else $error("result word not loaded after query");

   // The velocity magnitude never exceeds the configured speed.
   a_vel_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DIV_X || state_ff == ST_DIV_Y) && div_done) |->
      (div_q <= speed_ff))
      else $error("velocity magnitude above speed");

   // A word that reports no move carries zero velocity.
   a_still_zero_vel: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_tuser_ff) |-> (rsp_tdata_ff[2*VEL_W-1:0] == '0))
      else $error("nonzero velocity without a move");

endmodule

`default_nettype wire

[hw/rtl/nths_target_table.sv]
// Target slot table: valid marks and stored target positions.
`default_nettype none

module nths_target_table
   import nths_pkg::*;
#(
   parameter int DEPTH = 8,
   parameter int IDX_W = 3
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic [SLOT_W-1:0] wr_slot,
   input  wire logic              wr_valid,
   input  wire logic [POS_W-1:0]  wr_x,
   input  wire logic [POS_W-1:0]  wr_y,
   input  wire logic [IDX_W-1:0]  rd_idx,
   output logic                   rd_valid,
   output logic [POS_W-1:0]       rd_x,
   output logic [POS_W-1:0]       rd_y
);

   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;
   logic [POS_W-1:0] x_ff [DEPTH];
   logic [POS_W-1:0] y_ff [DEPTH];

   // A write to a slot beyond the table depth matches no entry and is dropped.
   always_comb begin
      valid_in = valid_ff;
      for (int i = 0; i < DEPTH; i++) begin
         if (wr_en && (int'(wr_slot) == i)) begin
            valid_in[i] = wr_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Positions are stored even when the slot is marked invalid.
   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         if (wr_en && (int'(wr_slot) == i)) begin
            x_ff[i] <= wr_x;
            y_ff[i] <= wr_y;
         end
      end
   end

   assign rd_valid = valid_ff[rd_idx];
   assign rd_x     = x_ff[rd_idx];
   assign rd_y     = y_ff[rd_idx];

endmodule

`default_nettype wire

[hw/rtl/nths_isqrt.sv]
// Iterative integer square root, two radicand bits per cycle.
`default_nettype none

module nths_isqrt
   import nths_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [SQ_W-1:0]  radicand,
   output logic                  done,
   output logic [ROOT_W-1:0]     root
);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [SQ_W-1:0] rem_ff, rem_in;
   logic [SQ_W-1:0] acc_ff, acc_in;
   logic [SQ_W-1:0] bit_ff, bit_in;
   logic [SQ_W:0]   trial;

   // One digit step: try to subtract the current root plus the bit weight.
   always_comb begin
      trial   = {1'b0, acc_ff} + {1'b0, bit_ff};
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = radicand;
         acc_in  = '0;
         bit_in  = SQ_W'(1) << (SQ_W - 2);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_in = rem_ff - trial[SQ_W-1:0];
            acc_in = (acc_ff >> 1) + bit_ff;
         end else begin
            acc_in = acc_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      acc_ff <= acc_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = acc_ff[ROOT_W-1:0];

   // The remainder of a floor square root never exceeds twice the root.
   a_root_remainder: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ({1'b0, rem_ff} <= {acc_ff, 1'b0}))
      else $error("square root remainder out of range");

endmodule

`default_nettype wire

[hw/rtl/nths_divider.sv]
// Iterative restoring divider for a quotient known to fit in Q_W bits.
`default_nettype none

module nths_divider
   import nths_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [NUM_W-1:0]  num,
   input  wire logic [ROOT_W-1:0] den,
   output logic                   done,
   output logic [Q_W-1:0]         quot
);

   localparam int CNT_W = $clog2(Q_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] dsh_ff, dsh_in;
   logic [Q_W-1:0]   quot_ff, quot_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             take;

   // One quotient bit per cycle, from the top bit down.
   always_comb begin
      take    = (rem_ff >= dsh_ff);
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num;
         dsh_in  = NUM_W'(den) << (Q_W - 1);
         quot_in = '0;
         cnt_in  = CNT_W'(Q_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (take) begin
            rem_in = rem_ff - dsh_ff;
         end
         quot_in = {quot_ff[Q_W-2:0], take};
         dsh_in  = dsh_ff >> 1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

[tb/sv/nths_step_checker.sv]
// Checker for the nearest-target homing step: predicts each query result and compares it.
`timescale 1ns / 1ps

module nths_step_checker
   import nths_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tready,
   // slot[2:0], slot_valid[3], pos_x[19:4], pos_y[35:20], zero fill above
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // kind[0]
   input  wire logic                   req_tuser,
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   // vel_x[8:0], vel_y[17:9], new_x[33:18], new_y[49:34], zero fill above
   input  wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   // moved[0]
   input  wire logic                   rsp_tuser,
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   input  wire logic [CSR_DATA_W-1:0]  csr_prdata,
   input  wire logic                   csr_pready,
   output int                          mismatches,
   output int                          outstanding
);

   localparam logic [CSR_ADDR_W-1:0] SPEED_ADDR = CSR_ADDR_W'(4 * int'(REG_SPEED));

   typedef struct {
      bit moved;
      int vel_x;
      int vel_y;
      int new_x;
      int new_y;
   } step_result_type;

   // Shadow of the target table and the speed register.
   logic                      tgt_valid [SLOT_COUNT];
   logic signed [POS_W-1:0]   tgt_x [SLOT_COUNT];
   logic signed [POS_W-1:0]   tgt_y [SLOT_COUNT];
   logic [SPEED_W-1:0]        speed_reg = SPEED_RESET;

   // Expected results of accepted queries, oldest first.
   step_result_type pending_steps [$];

   // Floor of the square root, found by binary search over the root.
   function automatic longint floor_sqrt(input longint n);
      longint lo;
      longint hi;
      longint mid;
      lo = 0;
      hi = longint'(1) << 20;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         if (mid * mid <= n)
            lo = mid;
         else
            hi = mid - 1;
      end
      return lo;
   endfunction

   // Scales one axis of the offset by speed over the distance, truncating toward zero.
   function automatic longint scale_axis(input longint d, input longint mag);
      longint a;
      longint q;
      a = (d < 0) ? -d : d;
      q = (a * longint'(speed_reg)) / mag;
      return (d < 0) ? -q : q;
   endfunction

   function automatic longint clamp16(input longint v);
      if (v > 32767)
         return 32767;
      if (v < -32768)
         return -32768;
      return v;
   endfunction

   // Nearest valid target by squared distance, lowest slot on a tie, then one step toward it.
   function automatic step_result_type homing_step(input logic signed [POS_W-1:0] px,
                                                   input logic signed [POS_W-1:0] py);
      step_result_type r;
      bit           found;
      longint       best;
      longint       dx;
      longint       dy;
      longint       d2;
      longint       bdx;
      longint       bdy;
      longint       mag;
      longint       vx;
      longint       vy;
      found = 1'b0;
      best = 0;
      bdx = 0;
      bdy = 0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (tgt_valid[i]) begin
            dx = longint'(tgt_x[i]) - longint'(px);
            dy = longint'(tgt_y[i]) - longint'(py);
            d2 = dx * dx + dy * dy;
            if (!found || d2 < best) begin
               found = 1'b1;
               best = d2;
               bdx = dx;
               bdy = dy;
            end
         end
      end
      r.moved = 1'b0;
      r.vel_x = 0;
      r.vel_y = 0;
      r.new_x = int'(px);
      r.new_y = int'(py);
      if (found && best != 0) begin
         mag = floor_sqrt(best);
         vx = scale_axis(bdx, mag);
         vy = scale_axis(bdy, mag);
         r.moved = 1'b1;
         r.vel_x = int'(vx);
         r.vel_y = int'(vy);
         r.new_x = int'(clamp16(longint'(px) + vx));
         r.new_y = int'(clamp16(longint'(py) + vy));
      end
      return r;
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   // All three channels are sampled at the rising edge, before the block updates.
   always @(posedge clock) begin : monitor
      step_result_type want;
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            tgt_valid[i] = 1'b0;
            tgt_x[i] = '0;
            tgt_y[i] = '0;
         end
         speed_reg = SPEED_RESET;
         pending_steps.delete();
         mismatches = 0;
      end else begin
         // Register access: writes update the shadow, reads of speed are checked.
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr == SPEED_ADDR)
                  speed_reg = csr_pwdata[SPEED_W-1:0];
            end else if (csr_paddr == SPEED_ADDR) begin
               check_field("prdata", longint'(speed_reg), longint'(csr_prdata));
            end
         end

         // Result word against the oldest expectation.
         if (rsp_tvalid && rsp_tready) begin
            if (pending_steps.size() == 0) begin
               $error("result word with no query waiting: tdata %h tuser %b",
                      rsp_tdata, rsp_tuser);
               mismatches++;
            end else begin
               want = pending_steps.pop_front();
               check_field("moved", longint'(want.moved), longint'(rsp_tuser));
               check_field("vel_x", want.vel_x, longint'($signed(rsp_tdata[8:0])));
               check_field("vel_y", want.vel_y, longint'($signed(rsp_tdata[17:9])));
               check_field("new_x", want.new_x, longint'($signed(rsp_tdata[33:18])));
               check_field("new_y", want.new_y, longint'($signed(rsp_tdata[49:34])));
               check_field("tdata zero fill", 0, longint'(rsp_tdata[RSP_TDATA_W-1:50]));
            end
         end

         // Request word: a target write updates the table, a query is predicted.
         if (req_tvalid && req_tready) begin
            if (req_tuser == KIND_WRITE) begin
               tgt_valid[req_tdata[2:0]] = req_tdata[3];
               tgt_x[req_tdata[2:0]] = req_tdata[19:4];
               tgt_y[req_tdata[2:0]] = req_tdata[35:20];
            end else begin
               pending_steps.push_back(homing_step(req_tdata[19:4], req_tdata[35:20]));
            end
         end
      end
      outstanding <= pending_steps.size();
   end

endmodule

[tb/sv/nearest_target_homing_step_tb.sv]
// Testbench top for the nearest-target homing step: stimulus, register setup and verdict.
`timescale 1ns / 1ps

module nearest_target_homing_step_tb;
   import nths_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE_CYCLES = 80;
   localparam logic [CSR_ADDR_W-1:0] SPEED_ADDR = CSR_ADDR_W'(4 * int'(REG_SPEED));
   localparam logic [CSR_ADDR_W-1:0] UNUSED_ADDR = CSR_ADDR_W'(4 * (int'(REG_SPEED) + 1));

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // slot[2:0], slot_valid[3], pos_x[19:4], pos_y[35:20], zero fill above
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   // kind[0]
   logic                   req_tuser = KIND_WRITE;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // vel_x[8:0], vel_y[17:9], new_x[33:18], new_y[49:34], zero fill above
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // moved[0]
   logic                   rsp_tuser;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   int mismatches;
   int outstanding;

   // Idling controls shared with the result sink.
   bit req_idle_on = 1'b0;
   bit rsp_idle_on = 1'b0;
   int rx_hold_cycles = 0;

   // Positions last written to each slot, used to aim queries and writes at them.
   logic [POS_W-1:0] shadow_x [SLOT_COUNT];
   logic [POS_W-1:0] shadow_y [SLOT_COUNT];

   nearest_target_homing_step u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   nths_step_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Result sink: random stall bursts, plus one long hold-off when requested.
   initial begin : result_sink
      int n;
      forever begin
         if (rx_hold_cycles != 0) begin
            n = rx_hold_cycles;
            rx_hold_cycles = 0;
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end else if (rsp_idle_on && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   // Watchdog on the whole run.
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("nearest_target_homing_step test failed");
      $finish;
   end

   // Offers one request word and waits for it to be taken, then maybe idles.
   task automatic send_word(input logic kind, input logic [SLOT_W-1:0] slot,
                            input logic slot_valid, input logic [POS_W-1:0] x,
                            input logic [POS_W-1:0] y);
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {4'b0, y, x, slot_valid, slot};
      do @(posedge clock); while (!req_tready);
      if (kind == KIND_WRITE) begin
         shadow_x[slot] = x;
         shadow_y[slot] = y;
      end
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // Stops offering words and waits until every query has its result.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // One register access: setup cycle, then access cycle until pready.
   task automatic csr_access(input logic write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Changes speed with the block idle, then reads it back.
   task automatic set_speed(input logic [SPEED_W-1:0] value);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_access(1'b1, SPEED_ADDR, CSR_DATA_W'(value));
      csr_access(1'b0, SPEED_ADDR, '0);
   endtask

   // Random words: mostly queries, coordinates drawn from a local cluster, the
   // range extremes, the full range, or an existing target's position.
   task automatic run_phase(input int count, input int valid_pct, input int hold_at);
      logic [POS_W-1:0]  cx;
      logic [POS_W-1:0]  cy;
      logic [POS_W-1:0]  x;
      logic [POS_W-1:0]  y;
      logic [SLOT_W-1:0] slot;
      logic [SLOT_W-1:0] aim;
      logic              kind;
      cx = POS_W'($urandom);
      cy = POS_W'($urandom);
      for (int n = 0; n < count; n++) begin
         if (n == hold_at)
            rx_hold_cycles = 1500;
         kind = ($urandom_range(0, 9) < 7) ? KIND_QUERY : KIND_WRITE;
         slot = SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
         aim = SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
         case ($urandom_range(0, 5))
            0: begin
               x = POS_W'($urandom);
               y = POS_W'($urandom);
            end
            1: begin
               x = $urandom_range(0, 1) ? 16'h7FFF - POS_W'($urandom_range(0, 15))
                                        : 16'h8000 + POS_W'($urandom_range(0, 15));
               y = $urandom_range(0, 1) ? 16'h7FFF - POS_W'($urandom_range(0, 15))
                                        : 16'h8000 + POS_W'($urandom_range(0, 15));
            end
            5: begin
               // On or right next to a stored target: zero distance and ties.
               x = shadow_x[aim] + POS_W'($urandom_range(0, 2)) - 16'd1;
               y = shadow_y[aim] + POS_W'($urandom_range(0, 2)) - 16'd1;
            end
            default: begin
               x = cx + POS_W'($urandom_range(0, 128)) - 16'd64;
               y = cy + POS_W'($urandom_range(0, 128)) - 16'd64;
            end
         endcase
         send_word(kind, slot, ($urandom_range(0, 99) < valid_pct), x, y);
      end
   endtask

   initial begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         shadow_x[i] = '0;
         shadow_y[i] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset value of speed, and a write to a register that does not exist.
      csr_access(1'b0, SPEED_ADDR, '0);
      csr_access(1'b1, UNUSED_ADDR, 32'hFFFF_FFFF);
      csr_access(1'b0, SPEED_ADDR, '0);

      // Directed words at the reset speed.
      send_word(KIND_QUERY, 3'd0, 1'b0, 16'h0000, 16'h0000);   // empty table
      send_word(KIND_WRITE, 3'd0, 1'b1, 16'h7FFF, 16'h7FFF);
      send_word(KIND_QUERY, 3'd0, 1'b0, 16'h8000, 16'h8000);   // longest diagonal
      send_word(KIND_QUERY, 3'd0, 1'b0, 16'h7FFF, 16'h7FFF);   // already on target
      send_word(KIND_WRITE, 3'd7, 1'b1, 16'h8000, 16'h8000);
      send_word(KIND_QUERY, 3'd5, 1'b1, 16'h7FFF, 16'h8000);   // tie, lower slot wins
      send_word(KIND_WRITE, 3'd3, 1'b1, 16'h7FFF, 16'h0000);
      send_word(KIND_QUERY, 3'd0, 1'b0, 16'h7FFD, 16'h0000);   // x saturates high
      send_word(KIND_WRITE, 3'd4, 1'b1, 16'h8000, 16'd100);
      send_word(KIND_QUERY, 3'd0, 1'b0, 16'h8002, 16'd100);    // x saturates low
      send_word(KIND_WRITE, 3'd3, 1'b0, 16'h0000, 16'h0000);   // invalidated slot
      send_word(KIND_QUERY, 3'd0, 1'b0, 16'h0001, 16'h0000);
      send_word(KIND_WRITE, 3'd5, 1'b1, 16'd100, -16'sd200);
      send_word(KIND_QUERY, 3'd0, 1'b0, 16'd103, -16'sd196);   // 3-4-5 offset
      send_word(KIND_QUERY, 3'd0, 1'b0, 16'd100, -16'sd199);   // unit offset
      send_word(KIND_WRITE, 3'd6, 1'b1, 16'hFFFF, 16'hFFFF);
      send_word(KIND_QUERY, 3'd0, 1'b0, 16'h0000, 16'h0000);
      send_word(KIND_WRITE, 3'd3, 1'b1, 16'hFFFF, 16'hFFFF);   // duplicate position
      send_word(KIND_QUERY, 3'd2, 1'b1, 16'h0002, 16'h0001);

      // Random phases over several speeds, with idling on one or both sides.
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      set_speed(8'd0);
      run_phase(80, 80, -1);

      set_speed(8'd255);
      run_phase(100, 80, 30);

      req_idle_on = 1'b0;
      set_speed(SPEED_W'($urandom_range(1, 254)));
      run_phase(100, 60, -1);

      req_idle_on = 1'b1;
      rsp_idle_on = 1'b0;
      set_speed(8'd1);
      run_phase(80, 30, -1);

      // Last part runs at full rate on both sides.
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      set_speed(SPEED_W'($urandom_range(0, 255)));
      run_phase(120, 80, -1);

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("nearest_target_homing_step test passed");
      else
         $display("nearest_target_homing_step test failed");
      $finish;
   end

endmodule
